### rtl/lpkt_pkg.sv
// Shared types, widths and codes of the linear-probing key table.
`timescale 1ns / 1ps

package lpkt_pkg;

	// Field widths of the request and response words.
	localparam int KIND_W   = 2;
	localparam int KEY_W    = 32;
	localparam int VAL_W    = 16;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 11;

	// Default table size and the load limit of three quarters.
	localparam int DEF_TABLE_SLOTS = 1024;
	localparam int LOAD_NUM        = 3;
	localparam int LOAD_DEN        = 4;

	// Key bits folded into the home-slot remainder per cycle.
	localparam int MOD_STEP = 4;

	// Operation codes.
	typedef enum logic [KIND_W-1:0] {
		KIND_LOOKUP = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_REMOVE = 2'd2
	} kind_e_t;

	// Response status codes.
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_EXISTS    = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	// Controller states.
	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_HOME,
		S_FIND,
		S_RM_CLEAR,
		S_RM_NEXT,
		S_RM_SCAN,
		S_RM_HOME,
		S_PLACE,
		S_DONE
	} state_t;

	// One slot of the table memory.
	typedef struct packed {
		logic             used;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] payload;
	} slot_t;

	localparam int SLOT_BITS = $bits(slot_t);

	// Result word handed from the controller to the output register.
	typedef struct packed {
		status_t          status;
		logic [VAL_W-1:0] found_value;
		logic [OCC_W-1:0] occupancy;
	} result_t;

endpackage

### rtl/lpkt_if.sv
// Valid/ready channel interfaces for request and response words.
`timescale 1ns / 1ps

interface lpkt_req_if;
	import lpkt_pkg::*;

	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [KEY_W-1:0]  key;
	logic [VAL_W-1:0]  entry_value;

	modport source (output valid, kind, key, entry_value, input ready);
	modport sink (input valid, kind, key, entry_value, output ready);
endinterface

interface lpkt_rsp_if;
	import lpkt_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [VAL_W-1:0]    found_value;
	logic [OCC_W-1:0]    occupancy;

	modport source (output valid, status, found_value, occupancy, input ready);
	modport sink (input valid, status, found_value, occupancy, output ready);
endinterface

### rtl/lpkt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lpkt_ram #(
	parameter int WIDTH = lpkt_pkg::SLOT_BITS,
	parameter int DEPTH = lpkt_pkg::DEF_TABLE_SLOTS,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port; a read at the written address returns old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/lpkt_home.sv
// Home-slot unit: reduces a key modulo the table size.
`timescale 1ns / 1ps

module lpkt_home #(
	parameter int TABLE_SLOTS = lpkt_pkg::DEF_TABLE_SLOTS,
	localparam int SW = $clog2(TABLE_SLOTS)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [lpkt_pkg::KEY_W-1:0] key,
	output logic                     done,
	output logic [SW-1:0]            home
);
	import lpkt_pkg::*;

	logic          done_q;
	logic [SW-1:0] home_q;

	assign done = done_q;
	assign home = home_q;

	if ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0) begin : g_pow2
		// A power-of-two size keeps the low key bits.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				done_q <= 1'b0;
			end else begin
				done_q <= start;
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				home_q <= key[SW-1:0];
			end
		end
	end else begin : g_serial
		localparam int STEPS = KEY_W / MOD_STEP;
		localparam int CNT_W = $clog2(STEPS);

		logic             busy_q;
		logic [CNT_W-1:0] cnt_q;
		logic [KEY_W-1:0] sh_q;
		logic [SW:0]      t;
		logic [SW-1:0]    rem_d;

		// Fold a few key bits into the remainder, one conditional subtract per bit.
		always_comb begin
			rem_d = home_q;
			t     = '0;
			for (int i = 0; i < MOD_STEP; i++) begin
				t = {rem_d, sh_q[KEY_W-1-i]};
				if (t >= (SW+1)'(TABLE_SLOTS)) begin
					t = t - (SW+1)'(TABLE_SLOTS);
				end
				rem_d = t[SW-1:0];
			end
		end

		// Iteration control.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				busy_q <= 1'b0;
				done_q <= 1'b0;
				cnt_q  <= '0;
			end else begin
				done_q <= 1'b0;
				if (start) begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end else if (busy_q) begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(STEPS - 1)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end

		// Remainder and remaining key bits.
		always_ff @(posedge clk) begin
			if (start) begin
				home_q <= '0;
				sh_q   <= key;
			end else if (busy_q) begin
				home_q <= rem_d;
				sh_q   <= sh_q << MOD_STEP;
			end
		end
	end

endmodule

### rtl/lpkt_ctrl.sv
// Probe controller: walks, reads, modifies and writes back the slot memory.
`timescale 1ns / 1ps

module lpkt_ctrl #(
	parameter int TABLE_SLOTS = lpkt_pkg::DEF_TABLE_SLOTS,
	localparam int SW = $clog2(TABLE_SLOTS)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	lpkt_req_if.sink                   req,
	output lpkt_pkg::result_t          res,
	output logic                       res_valid,
	input  logic                       res_ready,
	output logic                       mod_start,
	output logic [lpkt_pkg::KEY_W-1:0] mod_key,
	input  logic                       mod_done,
	input  logic [SW-1:0]              mod_home,
	output logic                       ram_we,
	output logic [SW-1:0]              ram_waddr,
	output lpkt_pkg::slot_t            ram_wdata,
	output logic [SW-1:0]              ram_raddr,
	input  lpkt_pkg::slot_t            ram_rdata
);
	import lpkt_pkg::*;

	localparam int CW      = $clog2(TABLE_SLOTS + 1);
	localparam int FULL_AT = (LOAD_NUM * TABLE_SLOTS + LOAD_DEN - 1) / LOAD_DEN;

	state_t            state_q, state_d;
	logic [CW-1:0]     count_q, count_d;
	logic [SW-1:0]     clr_q, clr_d;
	logic [KIND_W-1:0] kind_q, kind_d;
	logic [KEY_W-1:0]  key_q, key_d;
	logic [VAL_W-1:0]  val_q, val_d;
	logic [SW-1:0]     cur_q, cur_d;
	logic [CW-1:0]     nprobe_q, nprobe_d;
	logic [SW-1:0]     scan_q, scan_d;
	logic [CW-1:0]     scann_q, scann_d;
	logic [KEY_W-1:0]  mv_key_q, mv_key_d;
	logic [VAL_W-1:0]  mv_val_q, mv_val_d;
	status_t           status_q, status_d;
	logic [VAL_W-1:0]  found_q, found_d;
	logic              in_ready;
	logic              probe_limit;
	logic              key_hit;

	function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
		return (s == SW'(TABLE_SLOTS - 1)) ? '0 : s + 1'b1;
	endfunction

	assign req.ready       = in_ready;
	assign res.status      = status_q;
	assign res.found_value = found_q;
	assign res.occupancy   = OCC_W'(count_q);

	assign probe_limit = (nprobe_q == CW'(TABLE_SLOTS));
	assign key_hit     = ram_rdata.used && (ram_rdata.key == key_q);

	// Next state, memory access and result update.
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		clr_d     = clr_q;
		kind_d    = kind_q;
		key_d     = key_q;
		val_d     = val_q;
		cur_d     = cur_q;
		nprobe_d  = nprobe_q;
		scan_d    = scan_q;
		scann_d   = scann_q;
		mv_key_d  = mv_key_q;
		mv_val_d  = mv_val_q;
		status_d  = status_q;
		found_d   = found_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		mod_start = 1'b0;
		mod_key   = req.key;
		ram_we    = 1'b0;
		ram_waddr = cur_q;
		ram_wdata = '0;
		ram_raddr = next_slot(cur_q);

		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				clr_d     = clr_q + 1'b1;
				if (clr_q == SW'(TABLE_SLOTS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (req.valid) begin
					kind_d   = req.kind;
					key_d    = req.key;
					val_d    = req.entry_value;
					found_d  = '0;
					status_d = STAT_NOT_FOUND;
					unique case (req.kind)
						KIND_LOOKUP, KIND_INSERT, KIND_REMOVE: begin
							mod_start = 1'b1;
							state_d   = S_HOME;
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_HOME: begin
				if (mod_done) begin
					cur_d     = mod_home;
					ram_raddr = mod_home;
					nprobe_d  = '0;
					state_d   = S_FIND;
				end
			end
			S_FIND: begin
				// The read data belongs to cur_q; the next slot is read ahead.
				priority if (probe_limit || !ram_rdata.used) begin
					state_d = S_DONE;
					if (kind_q == KIND_INSERT) begin
						if (count_q >= CW'(FULL_AT) || probe_limit) begin
							status_d = STAT_FULL;
						end else begin
							ram_we    = 1'b1;
							ram_wdata = '{used: 1'b1, key: key_q, payload: val_q};
							count_d   = count_q + 1'b1;
							status_d  = STAT_OK;
						end
					end else begin
						status_d = STAT_NOT_FOUND;
					end
				end else if (key_hit) begin
					unique case (kind_q)
						KIND_LOOKUP: begin
							status_d = STAT_OK;
							found_d  = ram_rdata.payload;
							state_d  = S_DONE;
						end
						KIND_INSERT: begin
							status_d = STAT_EXISTS;
							state_d  = S_DONE;
						end
						default: begin
							status_d = STAT_OK;
							if (count_q != '0) begin
								count_d = count_q - 1'b1;
							end
							state_d = S_RM_CLEAR;
						end
					endcase
				end else begin
					cur_d    = next_slot(cur_q);
					nprobe_d = nprobe_q + 1'b1;
				end
			end
			S_RM_CLEAR: begin
				// Empty the removed slot, then walk the rest of its cluster.
				ram_we    = 1'b1;
				ram_waddr = cur_q;
				scan_d    = cur_q;
				scann_d   = '0;
				state_d   = S_RM_NEXT;
			end
			S_RM_NEXT: begin
				ram_raddr = next_slot(scan_q);
				scan_d    = next_slot(scan_q);
				state_d   = S_RM_SCAN;
			end
			S_RM_SCAN: begin
				if (scann_q == CW'(TABLE_SLOTS) || !ram_rdata.used) begin
					state_d = S_DONE;
				end else begin
					// Take the entry out and find its home again.
					scann_d   = scann_q + 1'b1;
					mv_key_d  = ram_rdata.key;
					mv_val_d  = ram_rdata.payload;
					ram_we    = 1'b1;
					ram_waddr = scan_q;
					mod_start = 1'b1;
					mod_key   = ram_rdata.key;
					state_d   = S_RM_HOME;
				end
			end
			S_RM_HOME: begin
				if (mod_done) begin
					cur_d     = mod_home;
					ram_raddr = mod_home;
					nprobe_d  = '0;
					state_d   = S_PLACE;
				end
			end
			S_PLACE: begin
				priority if (probe_limit) begin
					state_d = S_RM_NEXT;
				end else if (!ram_rdata.used) begin
					ram_we    = 1'b1;
					ram_wdata = '{used: 1'b1, key: mv_key_q, payload: mv_val_q};
					state_d   = S_RM_NEXT;
				end else begin
					cur_d    = next_slot(cur_q);
					nprobe_d = nprobe_q + 1'b1;
				end
			end
			S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			count_q <= '0;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			clr_q   <= clr_d;
		end
	end

	// Operand and walk registers.
	always_ff @(posedge clk) begin
		kind_q   <= kind_d;
		key_q    <= key_d;
		val_q    <= val_d;
		cur_q    <= cur_d;
		nprobe_q <= nprobe_d;
		scan_q   <= scan_d;
		scann_q  <= scann_d;
		mv_key_q <= mv_key_d;
		mv_val_q <= mv_val_d;
		status_q <= status_d;
		found_q  <= found_d;
	end

endmodule

### rtl/linear_probe_key_table.sv
// Linear-probing key table: lookup, insert and remove of 32-bit keys with 16-bit values.
// Steps: accept the word, find its home slot, probe slot by slot, hand on the result;
// a remove also empties the slot, then takes each following cluster entry out, finds
// its home and places it again. One operation at a time; the probe walk sets the pace.
// After reset a clearing pass empties every slot before any word is taken.
`timescale 1ns / 1ps

module linear_probe_key_table #(
	parameter int TABLE_SLOTS = lpkt_pkg::DEF_TABLE_SLOTS
) (
	input  logic       clk,
	input  logic       arst_n,
	lpkt_req_if.sink   req,
	lpkt_rsp_if.source rsp
);
	import lpkt_pkg::*;

	localparam int SW = $clog2(TABLE_SLOTS);

	result_t          res;
	logic             res_valid;
	logic             res_ready;
	logic             mod_start;
	logic [KEY_W-1:0] mod_key;
	logic             mod_done;
	logic [SW-1:0]    mod_home;
	logic             ram_we;
	logic [SW-1:0]    ram_waddr;
	slot_t            ram_wdata;
	logic [SW-1:0]    ram_raddr;
	slot_t            ram_rdata;
	logic             out_valid_q;
	result_t          out_q;

	lpkt_ram #(
		.WIDTH(SLOT_BITS),
		.DEPTH(TABLE_SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	lpkt_home #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_home (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mod_start),
		.key   (mod_key),
		.done  (mod_done),
		.home  (mod_home)
	);

	lpkt_ctrl #(
		.TABLE_SLOTS(TABLE_SLOTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.res      (res),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.mod_start(mod_start),
		.mod_key  (mod_key),
		.mod_done (mod_done),
		.mod_home (mod_home),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	// Output register: holds a finished word while the next operation runs.
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_q.status;
	assign rsp.found_value = out_q.found_value;
	assign rsp.occupancy   = out_q.occupancy;

endmodule

### test/tb.sv
// Self-checking testbench for the linear-probing key table.
`timescale 1ns / 1ps

module tb;
	import lpkt_pkg::*;

	localparam int          SLOTS       = DEF_TABLE_SLOTS;
	localparam logic [1:0]  KIND_UNUSED = 2'd3;
	localparam int          CYCLE_LIMIT = 4_000_000;
	localparam int          DRAIN_WAIT  = 64;
	localparam int          HOLD_CYCLES = 300;
	localparam int          HOLD_AT     = 500;

	// One request word as offered to the table.
	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  entry_value;
	} table_op_t;

	logic clk;
	logic arst_n;

	lpkt_req_if req_ch ();
	lpkt_rsp_if rsp_ch ();

	linear_probe_key_table #(
		.TABLE_SLOTS(SLOTS)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// Mirror of the table contents, updated as each word is accepted.
	bit               mirror_used [SLOTS];
	logic [KEY_W-1:0] mirror_key  [SLOTS];
	logic [VAL_W-1:0] mirror_val  [SLOTS];
	int unsigned      mirror_count;

	table_op_t   op_backlog[$];
	result_t     awaited_results[$];
	bit          key_taken[logic [KEY_W-1:0]];
	int unsigned ops_accepted;
	int unsigned results_seen;
	int unsigned mismatches;
	int unsigned cycle_count;
	int unsigned hold_left;
	bit          hold_done;
	bit          req_taken;
	logic        calm_stretch;

	// Idling is switched off while this range of words goes in.
	assign calm_stretch = (ops_accepted >= 900) && (ops_accepted < 1200);

	// Returns the slot holding the key, or SLOTS when it is absent.
	function automatic int locate_key(logic [KEY_W-1:0] key);
		int s;
		s = key % SLOTS;
		for (int n = 0; n < SLOTS; n++) begin
			if (!mirror_used[s])
				return SLOTS;
			if (mirror_key[s] == key)
				return s;
			s = (s + 1) % SLOTS;
		end
		return SLOTS;
	endfunction

	// Puts an entry into the first free slot of its probe chain.
	function automatic bit settle_entry(logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
		int s;
		s = key % SLOTS;
		for (int n = 0; n < SLOTS; n++) begin
			if (!mirror_used[s]) begin
				mirror_used[s] = 1'b1;
				mirror_key[s]  = key;
				mirror_val[s]  = value;
				return 1'b1;
			end
			s = (s + 1) % SLOTS;
		end
		return 1'b0;
	endfunction

	// Applies one operation to the mirror and returns the response it must produce.
	function automatic result_t predict_table_op(table_op_t op);
		result_t          res;
		int               s;
		int               j;
		logic [KEY_W-1:0] moved_key;
		logic [VAL_W-1:0] moved_val;
		res.status      = STAT_NOT_FOUND;
		res.found_value = '0;
		case (op.kind)
			KIND_LOOKUP: begin
				s = locate_key(op.key);
				if (s < SLOTS) begin
					res.status      = STAT_OK;
					res.found_value = mirror_val[s];
				end
			end
			KIND_INSERT: begin
				if (locate_key(op.key) < SLOTS)
					res.status = STAT_EXISTS;
				else if (mirror_count * LOAD_DEN >= SLOTS * LOAD_NUM)
					res.status = STAT_FULL;
				else if (settle_entry(op.key, op.entry_value)) begin
					mirror_count++;
					res.status = STAT_OK;
				end else
					res.status = STAT_FULL;
			end
			KIND_REMOVE: begin
				s = locate_key(op.key);
				if (s < SLOTS) begin
					mirror_used[s] = 1'b0;
					if (mirror_count > 0)
						mirror_count--;
					res.status = STAT_OK;
					// Pull every following entry of the cluster out and place it again.
					j = s;
					for (int n = 0; n < SLOTS; n++) begin
						j = (j + 1) % SLOTS;
						if (!mirror_used[j])
							break;
						moved_key      = mirror_key[j];
						moved_val      = mirror_val[j];
						mirror_used[j] = 1'b0;
						void'(settle_entry(moved_key, moved_val));
					end
				end
			end
			default: begin
				// The unused kind leaves the table alone.
			end
		endcase
		res.occupancy = mirror_count[OCC_W-1:0];
		return res;
	endfunction

	// Prints one mismatch line and counts it.
	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t: response %0d, %s: got %0h, expected %0h",
			$realtime, results_seen, what, got, want);
		mismatches++;
	endtask

	task automatic queue_op(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
		logic [VAL_W-1:0] value);
		table_op_t op;
		op.kind        = kind;
		op.key         = key;
		op.entry_value = value;
		op_backlog.push_back(op);
	endtask

	// Draws a random key that no earlier word has used.
	function automatic logic [KEY_W-1:0] fresh_key();
		logic [KEY_W-1:0] k;
		k = $urandom();
		while (key_taken.exists(k))
			k = $urandom();
		key_taken[k] = 1'b1;
		return k;
	endfunction

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Request driver: a new word goes out once the previous one was taken.
	always @(negedge clk) begin : drive_req
		table_op_t nxt;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_taken) begin
			if (op_backlog.size() != 0 && (calm_stretch || $urandom_range(99) >= 15)) begin
				nxt = op_backlog.pop_front();
				req_ch.valid       <= 1'b1;
				req_ch.kind        <= nxt.kind;
				req_ch.key         <= nxt.key;
				req_ch.entry_value <= nxt.entry_value;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Response side back-pressure, with one long hold-off.
	always @(negedge clk) begin
		if (!arst_n)
			rsp_ch.ready <= 1'b0;
		else
			rsp_ch.ready <= (hold_left == 0) && (calm_stretch || $urandom_range(99) >= 15);
	end

	// Counts the hold-off down once it has been started.
	always @(posedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
		else if (!hold_done && results_seen >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// Monitor: checks each response word and predicts each accepted request word.
	always @(posedge clk) begin : watch
		result_t  want;
		table_op_t op;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("response with no request pending", rsp_ch.status, 0);
			end else begin
				want = awaited_results.pop_front();
				if (rsp_ch.status !== want.status)
					report_mismatch("status", rsp_ch.status, want.status);
				if (rsp_ch.found_value !== want.found_value)
					report_mismatch("found_value", rsp_ch.found_value, want.found_value);
				if (rsp_ch.occupancy !== want.occupancy)
					report_mismatch("occupancy", rsp_ch.occupancy, want.occupancy);
			end
			results_seen++;
		end
		req_taken = arst_n && req_ch.valid && req_ch.ready;
		if (req_taken) begin
			op.kind        = req_ch.kind;
			op.key         = req_ch.key;
			op.entry_value = req_ch.entry_value;
			awaited_results.push_back(predict_table_op(op));
			ops_accepted++;
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		logic [KEY_W-1:0] pool[$];
		logic [KEY_W-1:0] fill_keys[$];
		logic [KEY_W-1:0] k;
		int unsigned      pick;
		int unsigned      idx;
		req_ch.valid       = 1'b0;
		req_ch.kind        = '0;
		req_ch.key         = '0;
		req_ch.entry_value = '0;
		rsp_ch.ready       = 1'b0;
		arst_n             = 1'b0;
		mirror_count       = 0;
		ops_accepted       = 0;
		results_seen       = 0;
		mismatches         = 0;
		cycle_count        = 0;
		hold_left          = 0;
		hold_done          = 1'b0;
		req_taken          = 1'b0;
		foreach (mirror_used[i])
			mirror_used[i] = 1'b0;

		// Directed words: wraparound clusters, duplicates, misses, cluster repair.
		key_taken[32'h0000_0000] = 1'b1;
		key_taken[32'hFFFF_FFFF] = 1'b1;
		key_taken[32'h0000_0400] = 1'b1;
		key_taken[32'h0000_07FF] = 1'b1;
		key_taken[32'h5555_5555] = 1'b1;
		queue_op(KIND_LOOKUP, 32'h0000_0000, 16'h0000);
		queue_op(KIND_REMOVE, 32'h0000_0005, 16'hFFFF);
		queue_op(KIND_INSERT, 32'h0000_0000, 16'h0000);
		queue_op(KIND_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
		queue_op(KIND_INSERT, 32'h0000_0400, 16'h1234);
		queue_op(KIND_INSERT, 32'h0000_07FF, 16'hA5A5);
		queue_op(KIND_INSERT, 32'h0000_0000, 16'h0007);
		queue_op(KIND_LOOKUP, 32'h0000_07FF, 16'h0000);
		queue_op(KIND_LOOKUP, 32'hFFFF_FFFF, 16'h0000);
		queue_op(KIND_LOOKUP, 32'h0000_0800, 16'h0000);
		queue_op(KIND_REMOVE, 32'hFFFF_FFFF, 16'h0000);
		queue_op(KIND_LOOKUP, 32'h0000_07FF, 16'h0000);
		queue_op(KIND_LOOKUP, 32'h0000_0400, 16'h0000);
		queue_op(KIND_REMOVE, 32'h0000_0000, 16'h0000);
		queue_op(KIND_LOOKUP, 32'h0000_0400, 16'h0000);
		queue_op(KIND_UNUSED, 32'h0000_07FF, 16'h0001);
		queue_op(KIND_LOOKUP, 32'hFFFF_FFFF, 16'h0000);
		queue_op(KIND_REMOVE, 32'h0000_0400, 16'h0000);
		queue_op(KIND_REMOVE, 32'h0000_07FF, 16'h0000);
		queue_op(KIND_INSERT, 32'h5555_5555, 16'h5555);
		queue_op(KIND_LOOKUP, 32'hAAAA_AAAA, 16'h0000);
		queue_op(KIND_REMOVE, 32'h5555_5555, 16'h0000);

		// A pool of keys whose home slots straddle the wrap point, so clusters form.
		while (pool.size() < 48) begin
			k = ($urandom() & 32'hFFFF_FC00) | ((1016 + pool.size() % 16) % SLOTS);
			if (!key_taken.exists(k)) begin
				key_taken[k] = 1'b1;
				pool.push_back(k);
			end
		end

		// Mixed traffic on the clustered pool.
		repeat (450) begin
			pick = $urandom_range(99);
			if ($urandom_range(99) < 85)
				k = pool[$urandom_range(pool.size() - 1)];
			else
				k = $urandom();
			if (pick < 40)
				queue_op(KIND_INSERT, k, 16'($urandom()));
			else if (pick < 75)
				queue_op(KIND_LOOKUP, k, 16'($urandom()));
			else if (pick < 95)
				queue_op(KIND_REMOVE, k, 16'($urandom()));
			else
				queue_op(KIND_UNUSED, k, 16'($urandom()));
		end

		// Fill the table past its load limit with fresh keys.
		repeat (880) begin
			if (fill_keys.size() != 0 && $urandom_range(9) == 0) begin
				queue_op(KIND_LOOKUP, fill_keys[$urandom_range(fill_keys.size() - 1)],
					16'h0000);
			end else begin
				k = fresh_key();
				fill_keys.push_back(k);
				queue_op(KIND_INSERT, k, 16'($urandom()));
			end
		end

		// Traffic at the load limit: refused inserts, duplicates, hits and a few removes.
		repeat (150) begin
			pick = $urandom_range(99);
			k    = fill_keys[$urandom_range(fill_keys.size() - 1)];
			if (pick < 45)
				queue_op(KIND_INSERT, fresh_key(), 16'($urandom()));
			else if (pick < 65)
				queue_op(KIND_INSERT, k, 16'($urandom()));
			else if (pick < 85)
				queue_op(KIND_LOOKUP, k, 16'($urandom()));
			else
				queue_op(KIND_REMOVE, k, 16'($urandom()));
		end

		// Drain part of the table again.
		repeat (300) begin
			idx = $urandom_range(fill_keys.size() - 1);
			if ($urandom_range(99) < 75) begin
				queue_op(KIND_REMOVE, fill_keys[idx], 16'($urandom()));
				fill_keys.delete(idx);
			end else begin
				queue_op(KIND_LOOKUP, fill_keys[idx], 16'($urandom()));
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for every word to go in and every response to come back.
		while (op_backlog.size() != 0 || req_ch.valid || awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
